[rtl/cubic_lane_curve_sampler_macros.svh]
// assertion macros shared by the lane curve sampler rtl
`ifndef CUBIC_LANE_CURVE_SAMPLER_MACROS_SVH
`define CUBIC_LANE_CURVE_SAMPLER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define CLS_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define CLS_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[rtl/cls_pkg.sv]
// types, constants and arithmetic helpers of the lane curve sampler
`timescale 1ns / 1ps
`default_nettype none
package cls_pkg;

	localparam int SAMPLES   = 10;
	localparam int FRAC_BITS = 24;
	localparam int STEP_W    = 25;
	localparam int X_W       = 31;
	localparam int COEF_W    = 32;
	localparam int IDX_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int NUM_W     = 63 + FRAC_BITS;
	localparam int DEN_W     = 40;
	localparam int Q_W       = 63;

	localparam logic [STEP_W-1:0] STEP_RESET = 25'd2516582;
	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] NMAX65 = -65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] I32_MIN = -64'sh0000_0000_8000_0000;

	// config register indexes
	localparam logic REG_SAMPLE_STEP = 1'b0;

	// one sample request from front to back
	typedef struct packed {
		logic [X_W-1:0]           x;
		logic                     last;
		logic signed [COEF_W-1:0] c0;
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c2;
		logic signed [COEF_W-1:0] c3;
	} sample_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic             start;
		logic             narrow;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic           busy;
		logic           done;
		logic [Q_W-1:0] quot;
	} div_rsp_t;

	// saturating 64-bit signed add, symmetric limits
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > SMAX65) s = SMAX65;
		if (s < NMAX65) s = NMAX65;
		return s[63:0];
	endfunction

	// clamp to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > I32_MAX) r = 32'sh7FFF_FFFF;
		if (v < I32_MIN) r = 32'sh8000_0000;
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/cls_if.sv]
// marker and point channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface cls_marker_if;
	import cls_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [COEF_W-1:0] offset;
	logic signed [COEF_W-1:0] heading;
	logic signed [COEF_W-1:0] curvature_coef;
	logic signed [COEF_W-1:0] curvature_rate;
	modport source (output valid, offset, heading, curvature_coef, curvature_rate,
		input ready);
	modport sink (input valid, offset, heading, curvature_coef, curvature_rate,
		output ready);
endinterface

interface cls_point_if;
	logic               valid;
	logic               ready;
	logic [30:0]        sample_x;
	logic signed [31:0] lateral;
	logic signed [31:0] slope;
	logic [30:0]        bend;
	logic               last_sample;
	modport source (output valid, sample_x, lateral, slope, bend, last_sample,
		input ready);
	modport sink (input valid, sample_x, lateral, slope, bend, last_sample,
		output ready);
endinterface
`default_nettype wire

[rtl/cls_front.sv]
// front end: takes markers and issues one sample request per point
`timescale 1ns / 1ps
`default_nettype none
module cls_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	cls_marker_if.sink                      marker,
	input  wire logic [cls_pkg::STEP_W-1:0] step,
	output logic                            push,
	output cls_pkg::sample_req_t            push_data,
	input  wire logic                       full
);
	import cls_pkg::*;

	logic                     busy_q;
	logic [IDX_W-1:0]         idx_q;
	logic [X_W-1:0]           x_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [COEF_W-1:0] c0_q, c1_q, c2_q, c3_q;
	logic                     fire, last, take;

	// request handshake toward the queue
	assign last = (idx_q == IDX_W'(SAMPLES - 1));
	assign push = busy_q;
	assign fire = busy_q && !full;
	assign marker.ready = !busy_q || (fire && last);
	assign take = marker.valid && marker.ready;

	assign push_data = '{x: x_q, last: last, c0: c0_q, c1: c1_q, c2: c2_q, c3: c3_q};

	// sample sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (fire) begin
				if (last) busy_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	// coefficients and running x
	always_ff @(posedge clk) begin
		if (fire) x_q <= x_q + X_W'(step_q);
		if (take) begin
			x_q    <= '0;
			step_q <= step;
			c0_q   <= marker.offset;
			c1_q   <= marker.heading;
			c2_q   <= marker.curvature_coef;
			c3_q   <= marker.curvature_rate;
		end
	end

endmodule
`default_nettype wire

[rtl/cls_fifo.sv]
// short request queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module cls_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire cls_pkg::sample_req_t din,
	input  wire logic                pop,
	output cls_pkg::sample_req_t     dout,
	output cls_pkg::fifo_stat_t      stat
);
	import cls_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	sample_req_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wp_q, rp_q;
	logic [PTR_W:0]     cnt_q;
	logic               wr, rd;

	assign stat = '{full: (cnt_q == (PTR_W+1)'(DEPTH)), empty: (cnt_q == '0)};
	assign wr = push && !stat.full;
	assign rd = pop && !stat.empty;
	assign dout = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= din;
	end

endmodule
`default_nettype wire

[rtl/cls_div.sv]
// bit-serial restoring divider with saturation, one quotient bit per cycle while busy
`timescale 1ns / 1ps
`default_nettype none
module cls_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cls_pkg::div_req_t req,
	output cls_pkg::div_rsp_t rsp
);
	import cls_pkg::*;

	logic             busy_q, done_q;
	logic [5:0]       cnt_q;
	logic [DEN_W-1:0] den_q, rem_q, rem_nx;
	logic [Q_W-1:0]   sh_q, quot_q, sh_init;
	logic [55:0]      hi;
	logic             sat, ge;
	logic [DEN_W:0]   rem2;

	// leading part of the dividend decides saturation
	assign hi = req.narrow ? req.num[NUM_W-1:31] : {32'b0, req.num[NUM_W-1:63]};
	assign sat = (hi >= {16'b0, req.den});
	assign sh_init = req.narrow ? {req.num[30:0], 32'b0} : req.num[62:0];

	// one restoring step
	assign rem2 = {rem_q, sh_q[Q_W-1]};
	assign ge = (rem2 >= {1'b0, den_q});
	assign rem_nx = ge ? DEN_W'(rem2 - {1'b0, den_q}) : rem2[DEN_W-1:0];

	assign rsp = '{busy: busy_q, done: done_q, quot: quot_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (sat) done_q <= 1'b1;
				else busy_q <= 1'b1;
				cnt_q <= req.narrow ? 6'd30 : 6'd62;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q  <= req.den;
			rem_q  <= hi[DEN_W-1:0];
			sh_q   <= sh_init;
			quot_q <= sat ? (req.narrow ? Q_W'(32'h7FFF_FFFF) : SMAX[Q_W-1:0]) : '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			sh_q   <= {sh_q[Q_W-2:0], 1'b0};
			quot_q <= {quot_q[Q_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

[rtl/cls_engine.sv]
// back end: evaluates one sample point with a shared multiplier and root unit
`timescale 1ns / 1ps
`default_nettype none
module cls_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	output logic               pop,
	input  wire cls_pkg::sample_req_t req,
	input  wire logic          empty,
	cls_point_if.source        point,
	output cls_pkg::div_req_t  div_req,
	input  wire cls_pkg::div_rsp_t div_rsp
);
	import cls_pkg::*;

	typedef enum logic [3:0] {
		E_IDLE, E_LOAD, E_MUL_LO, E_MUL_HI, E_MUL_SUM, E_ADD, E_SQ, E_D2,
		E_SQRT, E_DIVA, E_DIVA_W, E_DIVB, E_DIVB_W, E_DONE
	} state_t;

	state_t             state_q;
	sample_req_t        cur_q;
	logic [2:0]         k_q;
	logic signed [63:0] h_q, nv_q;
	logic [62:0]        plo_q;
	logic [61:0]        phi_q;
	logic signed [31:0] lat_q, s_q;
	logic [63:0]        sq_q, sv_q, root_q;
	logic [DEN_W-1:0]   d2_q;
	logic [4:0]         cnt_q;
	logic [Q_W-1:0]     q_q;
	logic [30:0]        bend_q;
	div_req_t           div_req_q;

	logic               out_valid_q, out_last_q;
	logic [X_W-1:0]     out_x_q;
	logic signed [31:0] out_lat_q, out_slope_q;
	logic [30:0]        out_bend_q;

	logic signed [63:0] c3x, c3x3, c3x6, addend, load_v, sum_w, h_neg;
	logic [62:0]        amag, nvmag, mr;
	logic [94:0]        full;
	logic [31:0]        su;
	logic [DEN_W-1:0]   d2_w;
	logic [63:0]        bitv, trial;

	// multiples of the cubic coefficient by shift and add
	assign c3x  = 64'(cur_q.c3);
	assign c3x3 = (c3x <<< 1) + c3x;
	assign c3x6 = c3x3 <<< 1;

	// seed and addend of each horner step
	always_comb begin
		case (k_q)
			3'd3:    load_v = c3x3;
			3'd5:    load_v = c3x6;
			default: load_v = c3x;
		endcase
		case (k_q)
			3'd0:    addend = 64'(cur_q.c2);
			3'd1:    addend = 64'(cur_q.c1);
			3'd2:    addend = 64'(cur_q.c0);
			3'd4:    addend = 64'(cur_q.c1);
			default: addend = 64'(cur_q.c2) <<< 1;
		endcase
	end

	// magnitude product, truncated and saturated
	assign h_neg = -h_q;
	assign amag  = h_q[63] ? h_neg[62:0] : h_q[62:0];
	assign full  = {1'b0, phi_q, 32'b0} + 95'(plo_q);
	assign mr    = (full[94:FRAC_BITS] > 71'(SMAX)) ? SMAX[62:0] : full[62+FRAC_BITS:FRAC_BITS];
	assign sum_w = sadd(h_q, addend);

	assign su    = s_q[31] ? 32'(-s_q) : 32'(s_q);
	assign d2_w  = DEN_W'(1 << FRAC_BITS) + DEN_W'(sq_q >> FRAC_BITS);
	assign nvmag = nv_q[63] ? 63'(-nv_q) : nv_q[62:0];

	// square root step
	assign bitv  = 64'(1) << {cnt_q, 1'b0};
	assign trial = root_q + bitv;

	assign pop = (state_q == E_IDLE) && !empty;
	assign div_req = div_req_q;

	assign point.valid       = out_valid_q;
	assign point.sample_x    = out_x_q;
	assign point.lateral     = out_lat_q;
	assign point.slope       = out_slope_q;
	assign point.bend        = out_bend_q;
	assign point.last_sample = out_last_q;

	// sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			out_valid_q <= 1'b0;
			div_req_q   <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && point.ready && (state_q != E_DONE)) out_valid_q <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (!empty) begin
						cur_q   <= req;
						k_q     <= '0;
						state_q <= E_LOAD;
					end
				end
				E_LOAD: begin
					h_q     <= load_v;
					state_q <= E_MUL_LO;
				end
				E_MUL_LO: begin
					plo_q   <= amag[31:0] * cur_q.x;
					state_q <= E_MUL_HI;
				end
				E_MUL_HI: begin
					phi_q   <= amag[62:32] * cur_q.x;
					state_q <= E_MUL_SUM;
				end
				E_MUL_SUM: begin
					h_q     <= h_q[63] ? -$signed({1'b0, mr}) : $signed({1'b0, mr});
					state_q <= E_ADD;
				end
				E_ADD: begin
					h_q <= sum_w;
					case (k_q)
						3'd2: begin
							lat_q   <= sat32(sum_w);
							k_q     <= 3'd3;
							state_q <= E_LOAD;
						end
						3'd4: begin
							s_q     <= sat32(sum_w);
							k_q     <= 3'd5;
							state_q <= E_LOAD;
						end
						3'd5: begin
							nv_q    <= sum_w;
							state_q <= E_SQ;
						end
						default: begin
							k_q     <= k_q + 1'b1;
							state_q <= E_MUL_LO;
						end
					endcase
				end
				E_SQ: begin
					sq_q    <= su * su;
					state_q <= E_D2;
				end
				E_D2: begin
					d2_q    <= d2_w;
					sv_q    <= 64'(d2_w) << FRAC_BITS;
					root_q  <= '0;
					cnt_q   <= 5'd31;
					state_q <= E_SQRT;
				end
				E_SQRT: begin
					if (sv_q >= trial) begin
						sv_q   <= sv_q - trial;
						root_q <= (root_q >> 1) + bitv;
					end else begin
						root_q <= root_q >> 1;
					end
					if (cnt_q == '0) state_q <= E_DIVA;
					else cnt_q <= cnt_q - 1'b1;
				end
				E_DIVA: begin
					div_req_q <= '{start: 1'b1, narrow: 1'b0,
						num: {nvmag, {FRAC_BITS{1'b0}}}, den: d2_q};
					state_q <= E_DIVA_W;
				end
				E_DIVA_W: begin
					div_req_q.start <= 1'b0;
					if (div_rsp.done) begin
						q_q     <= div_rsp.quot;
						state_q <= E_DIVB;
					end
				end
				E_DIVB: begin
					div_req_q <= '{start: 1'b1, narrow: 1'b1,
						num: {q_q, {FRAC_BITS{1'b0}}}, den: DEN_W'(root_q[31:0])};
					state_q <= E_DIVB_W;
				end
				E_DIVB_W: begin
					div_req_q.start <= 1'b0;
					if (div_rsp.done) begin
						bend_q  <= div_rsp.quot[30:0];
						state_q <= E_DONE;
					end
				end
				E_DONE: begin
					if (!out_valid_q || point.ready) begin
						out_valid_q <= 1'b1;
						out_x_q     <= cur_q.x;
						out_lat_q   <= lat_q;
						out_slope_q <= s_q;
						out_bend_q  <= bend_q;
						out_last_q  <= cur_q.last;
						state_q     <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/cubic_lane_curve_sampler.sv]
// top level of the cubic lane curve sampler
//
//  channel   dir  kind        contents
//  marker    in   valid/rdy   offset, heading, curvature_coef, curvature_rate
//  point     out  valid/rdy   sample_x, lateral, slope, bend, last_sample
//  apb       in   apb write   sample_step at byte address 0
//
// each point goes through these steps: taking the request, the horner and
// slope steps on the shared multiplier, the square, the bit-pair root, the
// two bit-serial divisions (a saturated one returns its limit without iterating)
// and loading the output register; a marker yields SAMPLES points.
// reset clears all control state; sample_step returns to 0.15.
// a four-entry request queue lets the front stall apart from the back.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_lane_curve_sampler_macros.svh"
module cubic_lane_curve_sampler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	cls_marker_if.sink       marker,
	cls_point_if.source      point,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import cls_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              cfg_wr;
	logic              q_push, q_pop;
	sample_req_t       q_din, q_dout;
	fifo_stat_t        q_stat;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_STEP);
	assign prdata = (paddr[2] == REG_SAMPLE_STEP) ? 32'(step_q) : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= STEP_RESET;
		else if (cfg_wr) step_q <= pwdata[STEP_W-1:0];
	end

	cls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.marker    (marker),
		.step      (step_q),
		.push      (q_push),
		.push_data (q_din),
		.full      (q_stat.full)
	);

	cls_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.stat   (q_stat)
	);

	cls_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop     (q_pop),
		.req     (q_dout),
		.empty   (q_stat.empty),
		.point   (point),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	cls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// internal consistency checks
	`CLS_ASSERT_NOW(a_q_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")
	`CLS_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`CLS_ASSERT_NEXT(a_div_runs, div_req.start, div_rsp.busy || div_rsp.done, "divider ignored start")
	`CLS_ASSERT_NOW(a_div_done_idle, div_rsp.done, !div_rsp.busy, "divider done while busy")

endmodule
`default_nettype wire
